// File: hw/rtl/mfrh_pkg.sv
// ----------------------------------------------------------------------------
// mfrh_pkg
// Types and constants shared by the MAC frame receive handshake block.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrh_pkg;

	// Frame type codes carried in the header.
	localparam logic [7:0] FT_START  = 8'd1;
	localparam logic [7:0] FT_DATA   = 8'd2;
	localparam logic [7:0] FT_ACK    = 8'd3;
	localparam logic [7:0] FT_BEACON = 8'd4;
	localparam logic [7:0] FT_PROBE  = 8'd5;

	// Result status codes.
	localparam logic [3:0] ST_BAD_LEN  = 4'd0;
	localparam logic [3:0] ST_NOT_ADDR = 4'd1;
	localparam logic [3:0] ST_DUP      = 4'd2;
	localparam logic [3:0] ST_BEACON   = 4'd3;
	localparam logic [3:0] ST_START    = 4'd4;
	localparam logic [3:0] ST_PROBE    = 4'd5;
	localparam logic [3:0] ST_DATA_ACK = 4'd6;
	localparam logic [3:0] ST_DATA_REF = 4'd7;
	localparam logic [3:0] ST_ACK      = 4'd8;
	localparam logic [3:0] ST_UNKNOWN  = 4'd9;

	// Acknowledgement kinds.
	localparam logic ACK_KIND_READY = 1'b0;
	localparam logic ACK_KIND_ACK   = 1'b1;

	// Configuration register map.
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ADDRESS = 8'd1;

	localparam logic [7:0] OWN_ADDRESS_RESET       = 8'd1;
	localparam logic [7:0] BROADCAST_ADDRESS_RESET = 8'd255;

	typedef struct packed {
		logic        frame_ok;
		logic [15:0] pkt_id;
		logic [7:0]  source_address;
		logic [7:0]  destination_address;
		logic [7:0]  frame_type;
		logic [15:0] wake_ivl;
		logic [31:0] now_ticks;
	} frame_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        ack_send;
		logic        ack_kind;
		logic [7:0]  ack_destination;
		logic [15:0] ack_pkt_id;
		logic        probe_armed;
		logic [7:0]  probe_partner;
		logic [3:0]  neighbor_slot;
	} result_t;

	// One neighbor table entry; an address of zero marks an empty slot.
	typedef struct packed {
		logic [7:0]  addr;
		logic [31:0] seen_at;
		logic [15:0] wake;
	} nbr_t;

endpackage

`default_nettype wire

// File: hw/rtl/mfrh_cell.sv
// ----------------------------------------------------------------------------
// mfrh_cell
// One storage cell of a ring: takes its neighbor's word or a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrh_cell #(
	parameter int unsigned W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         ld,
	input  wire logic [W-1:0] chain_d,
	input  wire logic [W-1:0] load_d,
	output logic      [W-1:0] q
);

	logic [W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (en) begin
			word_q <= ld ? load_d : chain_d;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

// File: hw/rtl/mac_frame_receive_handshake.sv
// ----------------------------------------------------------------------------
// mac_frame_receive_handshake
// Receive-side frame filter, duplicate check, neighbor table and handshake.
// ----------------------------------------------------------------------------
//  channel   signals                            handshake
//  frame     start, busy, frame                 taken when start && !busy
//  result    result_strobe, result              one cycle, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_index,   written when cfg_valid && cfg_ready
//            cfg_data
//
// A frame dropped for length or address goes straight to the result state. Any
// other frame walks the id history ring; a duplicate stops there, a new id is
// then pushed at the front of the ring. A new beacon then walks the neighbor
// ring twice, to search and to write. The done state builds the result, which
// shows on the cycle busy falls. Each ring has a single compare port, at the
// last cell of the history ring and at cell 0 of the neighbor ring. The
// receiver cannot stall. Reset clears the rings and the handshake state and
// sets the address registers to their reset values at once; there is no
// clearing pass.
`default_nettype none

module mac_frame_receive_handshake #(
	parameter int unsigned HISTORY_DEPTH  = 10,
	parameter int unsigned NEIGHBOR_SLOTS = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire mfrh_pkg::frame_t                     frame,
	output logic                                      result_strobe,
	output mfrh_pkg::result_t                         result,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mfrh_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [7:0]                           cfg_data
);

	localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned SW  = $clog2(NEIGHBOR_SLOTS + 1);
	localparam int unsigned NW  = $bits(mfrh_pkg::nbr_t);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_HSCAN  = 6'b000010,
		S_HPUSH  = 6'b000100,
		S_NSCAN  = 6'b001000,
		S_NWRITE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t             state_q;
	mfrh_pkg::frame_t   frame_q;
	mfrh_pkg::result_t  result_q;
	mfrh_pkg::result_t  res_d;
	logic               strobe_q;
	logic [7:0]         own_q;
	logic [7:0]         bcast_q;
	logic               ok_q;
	logic               addr_q;
	logic               dup_q;
	logic [HCW-1:0]     hcnt_q;
	logic [SW-1:0]      ncnt_q;
	logic               mfound_q;
	logic [SW-1:0]      midx_q;
	logic               efound_q;
	logic [SW-1:0]      eidx_q;
	logic [SW-1:0]      slot_d;
	logic               armed_q;
	logic [7:0]         partner_q;
	logic               armed_d;
	logic [7:0]         partner_d;
	logic               hist_hit;
	mfrh_pkg::nbr_t     nbr_new;
	mfrh_pkg::nbr_t     head;

	logic [15:0]        hist_v [HISTORY_DEPTH];
	logic [NW-1:0]      nbr_v  [NEIGHBOR_SLOTS];

	// History ring: every cell takes the one before it, so a rotation and a
	// push at the front move the same way; only the first cell's source differs.
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
		localparam int unsigned PREV = (i == 0) ? HISTORY_DEPTH - 1 : i - 1;
		mfrh_cell #(.W(16)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      ((state_q == S_HSCAN) || (state_q == S_HPUSH)),
			.ld      ((i == 0) && (state_q == S_HPUSH)),
			.chain_d (hist_v[PREV]),
			.load_d  (frame_q.pkt_id),
			.q       (hist_v[i])
		);
	end

	assign hist_hit = (hist_v[HISTORY_DEPTH-1] == frame_q.pkt_id);

	// Neighbor ring turns toward cell 0, so after k steps cell 0 holds slot k.
	// On the write pass the last cell takes the new entry in place of slot k.
	assign nbr_new = '{addr: frame_q.source_address, seen_at: frame_q.now_ticks,
		wake: frame_q.wake_ivl};

	for (genvar i = 0; i < NEIGHBOR_SLOTS; i++) begin : g_nbr
		localparam int unsigned NXT = (i == NEIGHBOR_SLOTS - 1) ? 0 : i + 1;
		mfrh_cell #(.W(NW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      ((state_q == S_NSCAN) || (state_q == S_NWRITE)),
			.ld      ((i == NEIGHBOR_SLOTS - 1) && (state_q == S_NWRITE) &&
				(ncnt_q == slot_d)),
			.chain_d (nbr_v[NXT]),
			.load_d  (nbr_new),
			.q       (nbr_v[i])
		);
	end

	assign head = nbr_v[0];

	// A known sender wins over the first empty slot.
	always_comb begin
		if (mfound_q) begin
			slot_d = midx_q;
		end else if (efound_q) begin
			slot_d = eidx_q;
		end else begin
			slot_d = SW'(NEIGHBOR_SLOTS);
		end
	end

	always_comb begin
		res_d                 = '0;
		res_d.status          = mfrh_pkg::ST_UNKNOWN;
		res_d.neighbor_slot   = 4'(NEIGHBOR_SLOTS);
		armed_d               = armed_q;
		partner_d             = partner_q;
		if (!ok_q) begin
			res_d.status = mfrh_pkg::ST_BAD_LEN;
		end else if (!addr_q) begin
			res_d.status = mfrh_pkg::ST_NOT_ADDR;
		end else if (dup_q) begin
			res_d.status = mfrh_pkg::ST_DUP;
		end else begin
			case (frame_q.frame_type)
				mfrh_pkg::FT_BEACON: begin
					res_d.status        = mfrh_pkg::ST_BEACON;
					res_d.neighbor_slot = 4'(slot_d);
				end
				mfrh_pkg::FT_START: begin
					res_d.status = mfrh_pkg::ST_START;
				end
				mfrh_pkg::FT_PROBE: begin
					res_d.status          = mfrh_pkg::ST_PROBE;
					res_d.ack_send        = 1'b1;
					res_d.ack_kind        = mfrh_pkg::ACK_KIND_READY;
					res_d.ack_destination = frame_q.source_address;
					res_d.ack_pkt_id      = frame_q.pkt_id;
					armed_d               = 1'b1;
					partner_d             = frame_q.source_address;
				end
				mfrh_pkg::FT_DATA: begin
					if (armed_q && (frame_q.source_address == partner_q)) begin
						res_d.status          = mfrh_pkg::ST_DATA_ACK;
						res_d.ack_send        = 1'b1;
						res_d.ack_kind        = mfrh_pkg::ACK_KIND_ACK;
						res_d.ack_destination = frame_q.source_address;
						res_d.ack_pkt_id      = frame_q.pkt_id;
						armed_d               = 1'b0;
						partner_d             = 8'd0;
					end else begin
						res_d.status = mfrh_pkg::ST_DATA_REF;
					end
				end
				mfrh_pkg::FT_ACK: begin
					res_d.status = mfrh_pkg::ST_ACK;
				end
				default: begin
					res_d.status = mfrh_pkg::ST_UNKNOWN;
				end
			endcase
		end
		res_d.probe_armed   = armed_d;
		res_d.probe_partner = partner_d;
	end

	// Header payload needs no reset.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			frame_q <= frame;
		end
		if (state_q == S_DONE) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			strobe_q  <= 1'b0;
			own_q     <= mfrh_pkg::OWN_ADDRESS_RESET;
			bcast_q   <= mfrh_pkg::BROADCAST_ADDRESS_RESET;
			ok_q      <= 1'b0;
			addr_q    <= 1'b0;
			dup_q     <= 1'b0;
			hcnt_q    <= '0;
			ncnt_q    <= '0;
			mfound_q  <= 1'b0;
			midx_q    <= '0;
			efound_q  <= 1'b0;
			eidx_q    <= '0;
			armed_q   <= 1'b0;
			partner_q <= 8'd0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == mfrh_pkg::REG_OWN_ADDRESS) begin
					own_q <= cfg_data;
				end else if (cfg_index == mfrh_pkg::REG_BROADCAST_ADDRESS) begin
					bcast_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ok_q     <= frame.frame_ok;
						addr_q   <= (frame.destination_address == own_q) ||
							(frame.destination_address == bcast_q);
						dup_q    <= 1'b0;
						mfound_q <= 1'b0;
						efound_q <= 1'b0;
						hcnt_q   <= '0;
						ncnt_q   <= '0;
						if (frame.frame_ok && ((frame.destination_address == own_q) ||
							(frame.destination_address == bcast_q))) begin
							state_q <= S_HSCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_HSCAN: begin
					if (hist_hit) begin
						dup_q <= 1'b1;
					end
					hcnt_q <= hcnt_q + 1'b1;
					if (hcnt_q == HCW'(HISTORY_DEPTH - 1)) begin
						state_q <= (dup_q || hist_hit) ? S_DONE : S_HPUSH;
					end
				end
				S_HPUSH: begin
					state_q <= (frame_q.frame_type == mfrh_pkg::FT_BEACON) ?
						S_NSCAN : S_DONE;
				end
				S_NSCAN: begin
					if (!mfound_q && (head.addr == frame_q.source_address)) begin
						mfound_q <= 1'b1;
						midx_q   <= ncnt_q;
					end
					if (!efound_q && (head.addr == 8'd0)) begin
						efound_q <= 1'b1;
						eidx_q   <= ncnt_q;
					end
					if (ncnt_q == SW'(NEIGHBOR_SLOTS - 1)) begin
						ncnt_q  <= '0;
						state_q <= S_NWRITE;
					end else begin
						ncnt_q <= ncnt_q + 1'b1;
					end
				end
				S_NWRITE: begin
					ncnt_q <= ncnt_q + 1'b1;
					if (ncnt_q == SW'(NEIGHBOR_SLOTS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					strobe_q  <= 1'b1;
					armed_q   <= armed_d;
					partner_q <= partner_d;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

`default_nettype wire

// File: hw/rtl/mfrh_checker.sv
// ----------------------------------------------------------------------------
// mfrh_checker
// Port-level checks on the MAC frame receive handshake block.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrh_checker #(
	parameter int unsigned NEIGHBOR_SLOTS = 10
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_strobe,
	input wire mfrh_pkg::result_t result
);

	// An accepted item always makes the block busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	// The result shows exactly when the block drops busy.
	a_strobe_at_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_strobe)
		else $error("busy fell without a result");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy)
		else $error("result shown while busy");

	// Without an acknowledgement its fields stay zero.
	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.ack_send |-> (result.ack_kind == 1'b0) &&
			(result.ack_destination == 8'd0) && (result.ack_pkt_id == 16'd0))
		else $error("acknowledgement fields set without an acknowledgement");

	// Only a new beacon reports a neighbor slot.
	a_slot_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.status != mfrh_pkg::ST_BEACON) |->
			(result.neighbor_slot == 4'(NEIGHBOR_SLOTS)))
		else $error("neighbor slot reported for a frame that is not a beacon");

endmodule

bind mac_frame_receive_handshake mfrh_checker #(
	.NEIGHBOR_SLOTS(NEIGHBOR_SLOTS)
) u_mfrh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.result        (result)
);

`default_nettype wire
